### hdl/space_packet_framer_defines.svh
// ----------------------------------------------------------------------------
// Space packet framer assertion macros
// Shared property shorthands for the framer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SPACE_PACKET_FRAMER_DEFINES_SVH
`define SPACE_PACKET_FRAMER_DEFINES_SVH

// The condition must never hold at a clock edge outside reset.
`define SPF_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define SPF_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hdl/spf_pkg.sv
// ----------------------------------------------------------------------------
// Space packet framer package
// Shared constants and types of the framer front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package spf_pkg;

	localparam int PAYLOAD_BYTES_DEF = 26;
	localparam int LEN_W = 6;
	localparam int POS_W = 7;
	localparam int APID_W = 11;
	localparam int SEQ_W = 14;
	localparam int HDR_BYTES = 6;

	localparam logic [2:0] VERSION_TYPE_SHDR = 3'b001;
	localparam logic [1:0] SEQ_FLAGS_UNSEG = 2'b11;

	typedef struct packed {
		logic             kind_name;
		logic             trunc;
		logic [SEQ_W-1:0] count;
		logic [LEN_W-1:0] len;
	} spf_desc_t;

	typedef struct packed {
		logic             en;
		logic             bank;
		logic [LEN_W-1:0] idx;
		logic [7:0]       data;
	} spf_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} spf_fifo_status_t;

endpackage

`default_nettype wire

### hdl/spf_front.sv
// ----------------------------------------------------------------------------
// Space packet framer front end
// Accepts words, stores payload bytes and issues packet descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_front #(
	parameter int PAYLOAD_BYTES = spf_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  is_name,
	input  wire logic                  end_of_run,
	input  wire logic                  fifo_full,
	output logic                       push,
	output spf_pkg::spf_desc_t         push_desc,
	output spf_pkg::spf_wr_t           wr
);
	import spf_pkg::*;

	localparam logic [LEN_W-1:0] CAP = LEN_W'(PAYLOAD_BYTES);

	logic [LEN_W-1:0] fill_q;
	logic [SEQ_W-1:0] seq_q;
	logic             drop_q;
	logic             bank_q;

	logic             acc;
	logic             full;
	logic [LEN_W-1:0] fill_inc;
	logic [LEN_W-1:0] new_fill;
	logic             emit;

	assign in_ready = !fifo_full;
	assign acc      = in_valid && in_ready;
	assign full     = (fill_q >= CAP);
	assign fill_inc = fill_q + LEN_W'(1);

	always_comb begin
		new_fill = full ? fill_q : fill_inc;
		if (is_name) begin
			emit = end_of_run;
		end else begin
			emit = full || (fill_inc >= CAP) || end_of_run;
		end
	end

	assign wr.en   = acc && !full;
	assign wr.bank = bank_q;
	assign wr.idx  = fill_q;
	assign wr.data = data_byte;

	assign push                = acc && emit;
	assign push_desc.kind_name = is_name;
	assign push_desc.trunc     = is_name && (drop_q || full);
	assign push_desc.count     = is_name ? '0 : seq_q;
	assign push_desc.len       = new_fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			seq_q  <= '0;
			drop_q <= 1'b0;
			bank_q <= 1'b0;
		end else if (acc) begin
			if (emit) begin
				fill_q <= '0;
				drop_q <= 1'b0;
				bank_q <= !bank_q;
				if (!is_name) begin
					seq_q <= seq_q + SEQ_W'(1);
				end
			end else begin
				fill_q <= new_fill;
				drop_q <= drop_q || (is_name && full);
			end
		end
	end

endmodule

`default_nettype wire

### hdl/spf_desc_fifo.sv
// ----------------------------------------------------------------------------
// Space packet framer descriptor queue
// Two-entry queue of packet descriptors, one per payload bank.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_desc_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire spf_pkg::spf_desc_t  push_desc,
	input  wire logic                pop,
	output spf_pkg::spf_desc_t       head,
	output spf_pkg::spf_fifo_status_t status
);
	import spf_pkg::*;

	spf_desc_t  entry_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign head         = entry_q[rptr_q];
	assign status.full  = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/spf_back.sv
// ----------------------------------------------------------------------------
// Space packet framer back end
// Holds the two payload banks and sends header and payload words.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_back #(
	parameter int PAYLOAD_BYTES = spf_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire spf_pkg::spf_wr_t          wr,
	input  wire spf_pkg::spf_desc_t        head,
	input  wire logic                      fifo_empty,
	output logic                           pop,
	output logic                           busy,
	input  wire logic [spf_pkg::APID_W-1:0] name_apid,
	input  wire logic [spf_pkg::APID_W-1:0] data_apid,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [7:0]                     out_byte,
	output logic                           end_of_packet,
	output logic                           name_truncated
);
	import spf_pkg::*;

	localparam int DEPTH = 2 * PAYLOAD_BYTES;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SEND = 2'b10
	} state_t;

	logic [7:0] mem [DEPTH];

	state_t           state_q;
	spf_desc_t        cur_q;
	logic [POS_W-1:0] pos_q;
	logic             rbank_q;
	logic [7:0]       rdata_s1;
	logic             ov_q;
	logic [7:0]       byte_q;
	logic             eop_q;
	logic             trunc_q;

	logic             adv;
	logic             last_pos;
	logic [POS_W-1:0] pos_d;
	logic [LEN_W-1:0] rd_idx;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [APID_W-1:0] apid;
	logic [15:0]      lenm1;
	logic [7:0]       sel_byte;

	assign busy     = (state_q == ST_SEND);
	assign pop      = (state_q == ST_IDLE) && !fifo_empty;
	assign adv      = busy && (!ov_q || out_ready);
	assign last_pos = (pos_q == (POS_W'(cur_q.len) + POS_W'(HDR_BYTES - 1)));

	always_comb begin
		if (pop) begin
			pos_d = '0;
		end else if (adv) begin
			pos_d = pos_q + POS_W'(1);
		end else begin
			pos_d = pos_q;
		end
	end

	assign rd_idx  = (pos_d < POS_W'(HDR_BYTES)) ? '0 : LEN_W'(pos_d - POS_W'(HDR_BYTES));
	assign rd_addr = rbank_q ? (AW'(PAYLOAD_BYTES) + AW'(rd_idx)) : AW'(rd_idx);
	assign wr_addr = wr.bank ? (AW'(PAYLOAD_BYTES) + AW'(wr.idx)) : AW'(wr.idx);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
		rdata_s1 <= mem[rd_addr];
	end

	assign apid  = cur_q.kind_name ? name_apid : data_apid;
	assign lenm1 = 16'(cur_q.len) - 16'd1;

	always_comb begin
		case (pos_q)
			POS_W'(0): sel_byte = {VERSION_TYPE_SHDR, 2'b00, apid[10:8]};
			POS_W'(1): sel_byte = apid[7:0];
			POS_W'(2): sel_byte = {SEQ_FLAGS_UNSEG, cur_q.count[13:8]};
			POS_W'(3): sel_byte = cur_q.count[7:0];
			POS_W'(4): sel_byte = lenm1[15:8];
			POS_W'(5): sel_byte = lenm1[7:0];
			default:   sel_byte = rdata_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		pos_q <= pos_d;
		if (adv) begin
			byte_q  <= sel_byte;
			eop_q   <= last_pos;
			trunc_q <= cur_q.kind_name && cur_q.trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rbank_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (adv && last_pos) begin
						state_q <= ST_IDLE;
						rbank_q <= !rbank_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (adv) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid      = ov_q;
	assign out_byte       = byte_q;
	assign end_of_packet  = eop_q;
	assign name_truncated = trunc_q;

endmodule

`default_nettype wire

### hdl/space_packet_framer.sv
// ----------------------------------------------------------------------------
// Space packet framer
// Packs file-name and file-data words into space packets with a 6-byte header.
// ----------------------------------------------------------------------------
// The front end takes one input word per cycle into one of two payload banks
// and closes a data packet when the bank is full or a run ends, a name packet
// only when its run ends; it stalls only while both banks wait to be sent. The
// back end sends n payload bytes as 6 + n output words, one per cycle unless
// out_ready stalls the output, returning to idle between packets, so the single
// output port sets the sustained rate. Registers: name_apid at byte address 0 and
// data_apid at 4, to be written only while idle; the block does not enforce it.
`default_nettype none

module space_packet_framer #(
	parameter int PAYLOAD_BYTES = spf_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_name,
	input  wire logic        end_of_run,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             end_of_packet,
	output logic             name_truncated
);
	import spf_pkg::*;

`include "space_packet_framer_defines.svh"

	localparam logic [APID_W-1:0] NAME_APID_RST = APID_W'(34);
	localparam logic [APID_W-1:0] DATA_APID_RST = APID_W'(35);

	logic [APID_W-1:0] name_apid_q;
	logic [APID_W-1:0] data_apid_q;
	logic              cfg_wr;

	logic             push;
	logic             pop;
	logic             busy;
	logic             front_stall;
	spf_desc_t        push_desc;
	spf_desc_t        head;
	spf_wr_t          wr;
	spf_fifo_status_t fifo_st;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? 32'(data_apid_q) : 32'(name_apid_q);

	// Both banks are taken when both wait in the queue, or when one is being sent and the other waits in it.
	assign front_stall = fifo_st.full || (busy && !fifo_st.empty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_apid_q <= NAME_APID_RST;
			data_apid_q <= DATA_APID_RST;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				data_apid_q <= pwdata[APID_W-1:0];
			end else begin
				name_apid_q <= pwdata[APID_W-1:0];
			end
		end
	end

	spf_front #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.is_name    (is_name),
		.end_of_run (end_of_run),
		.fifo_full  (front_stall),
		.push       (push),
		.push_desc  (push_desc),
		.wr         (wr)
	);

	spf_desc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.status    (fifo_st)
	);

	spf_back #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr             (wr),
		.head           (head),
		.fifo_empty     (fifo_st.empty),
		.pop            (pop),
		.busy           (busy),
		.name_apid      (name_apid_q),
		.data_apid      (data_apid_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.end_of_packet  (end_of_packet),
		.name_truncated (name_truncated)
	);

	`SPF_ASSERT_NEVER(a_no_push_full, push && fifo_st.full, "descriptor pushed into a full queue")
	`SPF_ASSERT_NEVER(a_no_pop_empty, pop && fifo_st.empty, "descriptor popped from an empty queue")
	`SPF_ASSERT_IMPLY(a_pop_idle, pop, !busy, "new packet started while another is being sent")

endmodule

`default_nettype wire
